// ----- rtl/aes128_block_encrypt_unit_assert.svh -----
// Assertion macros for the AES-128 encrypt unit.
// Needs no package; the including module supplies clock and reset names.
`ifndef AES128_BLOCK_ENCRYPT_UNIT_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define AES128_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("aes128 check failed: same-cycle implication");

// Next-cycle implication, checked out of reset only.
`define AES128_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("aes128 check failed: next-cycle implication");

`endif

// ----- rtl/aes128e_pkg.sv -----
// Shared types, constants and round functions of the AES-128 encrypt unit.
// No dependencies; imported by the top level.
`default_nettype none

package aes128e_pkg;

	localparam int NUM_ROUNDS  = 10;
	localparam int CFG_INDEX_W = 2;

	typedef logic [127:0] block_t;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_KEY_HIGH = CFG_INDEX_W'(0);
	localparam cfg_index_t REG_KEY_LOW  = CFG_INDEX_W'(1);

	localparam logic [7:0] GF_POLY = 8'h1b;

	localparam logic [7:0] RCON [0:NUM_ROUNDS-1] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	localparam logic [7:0] SBOX [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Multiply by two in GF(2^8).
	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
	endfunction

	// SubBytes and ShiftRows; byte 0 sits in the top bits, column-major.
	function automatic block_t sub_shift(input block_t s);
		block_t t;
		int src;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = (((c + r) & 3) * 4) + r;
				t[127 - 8 * (c * 4 + r) -: 8] = SBOX[s[127 - 8 * src -: 8]];
			end
		end
		return t;
	endfunction

	function automatic block_t mix_cols(input block_t s);
		block_t t;
		logic [7:0] a0, a1, a2, a3, all;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0  = s[127 - 32 * c -: 8];
			a1  = s[119 - 32 * c -: 8];
			a2  = s[111 - 32 * c -: 8];
			a3  = s[103 - 32 * c -: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

	// One step of the key schedule: four new words from the previous round key.
	function automatic block_t next_key(input block_t k, input logic [7:0] rc);
		logic [31:0] rot, w0, w1, w2, w3;
		rot = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
		w0  = k[127:96] ^ rot;
		w1  = k[95:64] ^ w0;
		w2  = k[63:32] ^ w1;
		w3  = k[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

`default_nettype wire

// ----- rtl/aes128_block_encrypt_unit.sv -----
// AES-128 encrypt unit: one 128-bit block per transfer through a pipeline of
// eleven register stages (key add, then one stage per round).
//
// Channels: plaintext in (in_valid/in_ready, plain_high/plain_low), ciphertext
// out (out_valid/out_ready, cipher_high/cipher_low), and a key write port
// (cfg_valid/cfg_ready, cfg_index/cfg_data). Index 0 writes key bytes 0..7,
// index 1 writes key bytes 8..15; other indices are dropped. cfg_ready is
// always high. Byte 0 sits in bits 63:56 of each high half.
// The round keys are derived stage by stage and travel with each block, so
// a key write applies to every block accepted after it.
// Blocks pass through the key-add stage and each round stage in order.
// Throughput: one block per cycle when the output is not stalled, set by the
// single round of S-box, MixColumns and key step between adjacent stages.
// Stalls: each stage holds while the stage after it is full and stalled;
// empty stages keep filling, so the input stops taking blocks only when all
// eleven stages hold data. Nothing is dropped or repeated.
// Reset: all stages empty, key registers cleared to the all-zero key.
`default_nettype none

`include "aes128_block_encrypt_unit_assert.svh"

module aes128_block_encrypt_unit
	import aes128e_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire cfg_index_t  cfg_index,
	input  wire logic [63:0] cfg_data,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] plain_high,
	input  wire logic [63:0] plain_low,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      cipher_high,
	output logic [63:0]      cipher_low
);

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;

	logic [NUM_ROUNDS:0] vld_s;
	logic [NUM_ROUNDS:0] stage_rdy;
	block_t              blk_s  [0:NUM_ROUNDS];
	block_t              rkey_s [0:NUM_ROUNDS-1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or its contents move on this cycle.
	always_comb begin
		stage_rdy[NUM_ROUNDS] = !vld_s[NUM_ROUNDS] || out_ready;
		for (int k = NUM_ROUNDS - 1; k >= 0; k--) begin
			stage_rdy[k] = !vld_s[k] || stage_rdy[k + 1];
		end
	end

	assign in_ready = stage_rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (stage_rdy[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k <= NUM_ROUNDS; k++) begin
				if (stage_rdy[k]) begin
					vld_s[k] <= vld_s[k - 1];
				end
			end
		end
	end

	// Entry stage: initial AddRoundKey, capture the key for the schedule.
	always_ff @(posedge clk) begin
		if (in_valid && stage_rdy[0]) begin
			blk_s[0]  <= {plain_high, plain_low} ^ {key_high_q, key_low_q};
			rkey_s[0] <= {key_high_q, key_low_q};
		end
	end

	for (genvar k = 1; k <= NUM_ROUNDS; k++) begin : g_round
		block_t rk_next;
		block_t subbed;
		block_t mixed;

		assign rk_next = next_key(rkey_s[k - 1], RCON[k - 1]);
		assign subbed  = sub_shift(blk_s[k - 1]);

		if (k == NUM_ROUNDS) begin : g_last
			assign mixed = subbed;
		end else begin : g_full
			assign mixed = mix_cols(subbed);

			always_ff @(posedge clk) begin
				if (vld_s[k - 1] && stage_rdy[k]) begin
					rkey_s[k] <= rk_next;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (vld_s[k - 1] && stage_rdy[k]) begin
				blk_s[k] <= mixed ^ rk_next;
			end
		end
	end

	assign out_valid   = vld_s[NUM_ROUNDS];
	assign cipher_high = blk_s[NUM_ROUNDS][127:64];
	assign cipher_low  = blk_s[NUM_ROUNDS][63:0];

	// Input back-pressure only when the whole pipeline is occupied.
	`AES128_ASSERT_IMPLY(a_full_when_blocked, clk, arst_n, !in_ready, &vld_s)

	// A block reaching the last round lands in the output stage.
	`AES128_ASSERT_NEXT(a_last_round_moves, clk, arst_n,
		vld_s[NUM_ROUNDS-1] && stage_rdy[NUM_ROUNDS], vld_s[NUM_ROUNDS])

	// A blocked entry stage keeps its block.
	`AES128_ASSERT_NEXT(a_entry_holds, clk, arst_n, vld_s[0] && !stage_rdy[0],
		vld_s[0] && $stable(blk_s[0]))

endmodule

`default_nettype wire
